### sv/bitmap_block_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a condition at every clock edge outside reset.
`define BBA_ASSERT_NOW(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bitmap allocator check failed");
// Check that a condition holds in the cycle after a trigger.
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap allocator sequence check failed");
`else
`define BBA_ASSERT_NOW(lbl, clk, rst_n, prop)
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/bba_pkg.sv
package bba_pkg;

  localparam int unsigned IDX_W          = 12;
  localparam int unsigned FUNC_W         = 2;
  localparam int unsigned STAT_W         = 2;
  localparam int unsigned NUM_BLOCKS_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF  = 64;

  // Request codes on in_func.
  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

  // Result codes on out_status.
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_LOOK,
    ST_SCAN,
    ST_RESP
  } bba_state_t;

endpackage

### sv/bba_map_ram.sv
module bba_map_ram import bba_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/bba_scan.sv
module bba_scan import bba_pkg::*; #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned PW        = 6,
  parameter int unsigned AVW       = 7
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [AVW-1:0]       avail,
  output logic                 found,
  output logic [PW-1:0]        pos,
  output logic [WORD_BITS-1:0] pick
);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_v;

  // Only the low avail bits of the word name real blocks.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (AVW'(i) < avail);
    end
  end

  assign free_v = ~word & mask;
  // Isolate the lowest free bit.
  assign pick   = free_v & (~free_v + WORD_BITS'(1));
  assign found  = |free_v;

  always_comb begin
    pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (pick[i]) begin
        pos = pos | PW'(i);
      end
    end
  end

endmodule

### sv/bitmap_block_allocator.sv
// Accept to out_valid: allocate scans k map words (1..MAP_WORDS) in ST_SCAN, then ST_RESP;
//   free and query pass ST_DIV, ST_ADDR, ST_LOOK, ST_RESP (no ST_LOOK for a free of block 0
//   or an index past the map); an unused code goes straight to ST_RESP. One request at a
//   time, taken in ST_IDLE; one find-first-free unit reads the map a word per cycle. While a
//   result beat stalls, the next finished result waits and no request is taken.
// Reset: synchronous, active low; a clearing pass then writes all MAP_WORDS map words
//   (block 0 marked used), one per cycle, with in_stall high.
`include "bitmap_block_allocator_defines.svh"

module bitmap_block_allocator import bba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int unsigned WORD_BITS  = WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [IDX_W-1:0]  in_block_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_allocated_index,
  output logic              out_block_is_free,
  output logic [STAT_W-1:0] out_status
);

  // Map geometry.
  localparam int unsigned MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PW        = $clog2(WORD_BITS);
  localparam int unsigned AVW       = $clog2(WORD_BITS + 1);
  localparam int unsigned RW        = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CW        = (RW > IDX_W) ? RW : IDX_W;

  // Word index of a block by reciprocal multiply; exact for 12-bit indexes
  // since 2^DIV_SH is far above 4096 * WORD_BITS.
  localparam int unsigned DIV_SH    = 24;
  localparam int unsigned DPW       = IDX_W + DIV_SH + 1;
  localparam logic [DPW-1:0] DIV_RECIP = DPW'((2**DIV_SH + WORD_BITS - 1) / WORD_BITS);
  localparam logic [IDX_W-1:0] WB_I    = IDX_W'(WORD_BITS);

  bba_state_t        state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  q_r, q_nxt;
  logic [PW-1:0]     bit_r, bit_nxt;
  logic [AW-1:0]     word_r, word_nxt;
  logic [RW-1:0]     base_r, base_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;
  logic [IDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic              res_free_r, res_free_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic              out_free_r, out_free_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic              in_acc;
  logic              out_load;
  logic [DPW-1:0]    div_prod;
  logic [IDX_W-1:0]  word_base;
  logic              idx_out_of_map;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [AVW-1:0]    scan_avail;
  logic              scan_found;
  logic [PW-1:0]     scan_pos;
  logic [WORD_BITS-1:0] scan_pick;

  // Used-map storage: one word per entry, registered read.
  bba_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW),
    .WIDTH (WORD_BITS)
  ) u_map (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Shared find-first-free unit, reused for every word of an allocate.
  bba_scan #(
    .WORD_BITS (WORD_BITS),
    .PW        (PW),
    .AVW       (AVW)
  ) u_scan (
    .word  (ram_rdata),
    .avail (scan_avail),
    .found (scan_found),
    .pos   (scan_pos),
    .pick  (scan_pick)
  );

  // Clip the last word to the blocks that really exist.
  assign scan_avail = (rem_r >= RW'(WORD_BITS)) ? AVW'(WORD_BITS) : AVW'(rem_r);

  assign in_acc   = in_valid && !in_stall;
  // The output register is free when empty or being drained this cycle.
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || !out_stall);

  assign div_prod       = DPW'(idx_r) * DIV_RECIP;
  assign word_base      = q_r * WB_I;
  assign idx_out_of_map = (CW'(idx_r) >= CW'(NUM_BLOCKS));

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    func_nxt      = func_r;
    idx_nxt       = idx_r;
    q_nxt         = q_r;
    bit_nxt       = bit_r;
    word_nxt      = word_r;
    base_nxt      = base_r;
    rem_nxt       = rem_r;
    res_idx_nxt   = res_idx_r;
    res_free_nxt  = res_free_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_free_nxt  = out_free_r;
    out_stat_nxt  = out_stat_r;
    in_stall      = 1'b1;
    ram_we        = 1'b0;
    ram_waddr     = word_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = '0;

    // Drop the result beat once the consumer takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        // Sweep the map once; block 0 stays reserved.
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = (clr_cnt_r == '0) ? WORD_BITS'(1) : '0;
        if (clr_cnt_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end

      ST_IDLE: begin
        in_stall  = 1'b0;
        // Fetch word 0 now so an allocate scan starts on the next cycle.
        ram_raddr = '0;
        // in_stall is low here, so a valid beat is taken.
        if (in_valid) begin
          func_nxt     = in_func;
          idx_nxt      = in_block_index;
          word_nxt     = '0;
          base_nxt     = '0;
          rem_nxt      = RW'(NUM_BLOCKS);
          res_idx_nxt  = '0;
          res_free_nxt = 1'b0;
          res_stat_nxt = STAT_OK;
          unique case (in_func)
            FN_ALLOC: state_nxt = ST_SCAN;
            FN_FREE:  state_nxt = ST_DIV;
            FN_QUERY: state_nxt = ST_DIV;
            default:  state_nxt = ST_RESP;
          endcase
        end
      end

      ST_DIV: begin
        q_nxt     = div_prod[IDX_W+DIV_SH-1:DIV_SH];
        state_nxt = ST_ADDR;
      end

      ST_ADDR: begin
        bit_nxt   = PW'(idx_r - word_base);
        ram_raddr = AW'(q_r);
        word_nxt  = AW'(q_r);
        priority if (idx_out_of_map) begin
          // No such block: free does nothing, query reports not free.
          state_nxt = ST_RESP;
        end else if (func_r == FN_FREE && idx_r == '0) begin
          res_stat_nxt = STAT_ZERO;
          state_nxt    = ST_RESP;
        end else begin
          state_nxt = ST_LOOK;
        end
      end

      ST_LOOK: begin
        if (func_r == FN_FREE) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~(WORD_BITS'(1) << bit_r);
        end else begin
          res_free_nxt = !ram_rdata[bit_r];
        end
        state_nxt = ST_RESP;
      end

      ST_SCAN: begin
        // Read the following word while this one is examined.
        ram_raddr = word_r + AW'(1);
        priority if (scan_found) begin
          ram_we      = 1'b1;
          ram_wdata   = ram_rdata | scan_pick;
          res_idx_nxt = IDX_W'(base_r + RW'(scan_pos));
          state_nxt   = ST_RESP;
        end else if (rem_r <= RW'(WORD_BITS)) begin
          res_stat_nxt = STAT_FULL;
          state_nxt    = ST_RESP;
        end else begin
          word_nxt = word_r + AW'(1);
          base_nxt = base_r + RW'(WORD_BITS);
          rem_nxt  = rem_r - RW'(WORD_BITS);
        end
      end

      ST_RESP: begin
        // Hold the result until the output register can take it.
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_free_nxt  = res_free_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    idx_r      <= idx_nxt;
    q_r        <= q_nxt;
    bit_r      <= bit_nxt;
    word_r     <= word_nxt;
    base_r     <= base_nxt;
    rem_r      <= rem_nxt;
    res_idx_r  <= res_idx_nxt;
    res_free_r <= res_free_nxt;
    res_stat_r <= res_stat_nxt;
    out_idx_r  <= out_idx_nxt;
    out_free_r <= out_free_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_allocated_index = out_idx_r;
  assign out_block_is_free   = out_free_r;
  assign out_status          = out_stat_r;

  // The block is busy in the cycle after every accepted beat.
  `BBA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, state_r != ST_IDLE)
  // Block 0 is reserved, so the first word never offers bit 0.
  `BBA_ASSERT_NOW(a_block0_reserved, clk, rst_n,
    !(state_r == ST_SCAN && word_r == '0 && scan_found) || scan_pos != '0)
  // The map is never written while waiting for a request or a consumer.
  `BBA_ASSERT_NOW(a_no_write_when_idle, clk, rst_n,
    !(state_r == ST_IDLE || state_r == ST_RESP) || !ram_we)
  // A loaded result shows up as a valid beat on the next cycle.
  `BBA_ASSERT_NEXT(a_result_presented, clk, rst_n, out_load, out_valid_r)

endmodule
